// ----- design/hgc_pkg.sv -----
// ----------------------------------------------------------------------------
// hgc_pkg
// Shared types and constants for the HDR ghost certainty pipeline.
// ----------------------------------------------------------------------------
package hgc_pkg;

  // Field widths.
  localparam int PIX_W   = 12;  // Q8.4 luma sample
  localparam int RATIO_W = 16;  // Q8.8 exposure ratio
  localparam int IDX_W   = 8;   // table index of a write word
  localparam int VAL_W   = 16;  // Q1.15 weight
  localparam int CFG_W   = 16;  // widest configuration register
  localparam int EXP_W   = 20;  // expected value in Q.12
  localparam int PROD_W  = PIX_W + RATIO_W;  // reference times ratio
  localparam int DIVD_W  = PIX_W + 16;       // reference shifted up by 16

  // Divider layout: quotient bits resolved, and bits per stage.
  localparam int Q_BITS     = EXP_W;
  localparam int DIV_BPS    = 2;
  localparam int DIV_STAGES = Q_BITS / DIV_BPS;

  // Certainty of one, and the 255.0 clamp of the reference-first mode.
  localparam logic [VAL_W-1:0]  CERT_ONE = 16'd32768;
  localparam logic [VAL_W-1:0]  CERT_ZERO = 16'd0;
  localparam logic [EXP_W-1:0]  SAT_EXP  = 20'd1044480;
  localparam logic [PROD_W-1:0] SAT_PROD = 28'd1044480;

  // Word operations.
  localparam logic OP_PIXEL       = 1'b0;
  localparam logic OP_TABLE_WRITE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_FIRST_IS_REF   = 2'd0,
    REG_EXPOSURE_RATIO = 2'd1,
    REG_NOISE_FLOOR    = 2'd2,
    REG_CLIP_LEVEL     = 2'd3
  } cfg_reg_t;

  // Current configuration, as seen by the pipeline.
  typedef struct packed {
    logic               first_is_reference;
    logic [RATIO_W-1:0] exposure_ratio;
    logic [PIX_W-1:0]   noise_floor;
    logic [PIX_W-1:0]   clip_level;
  } cfg_t;

  // Word fields that ride alongside the divider.
  typedef struct packed {
    logic              op;
    logic              force_one;
    logic              div_sat;
    logic [PIX_W-1:0]  meas;
    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  tbl_index;
    logic [VAL_W-1:0]  tbl_value;
  } side_t;

endpackage

// ----- design/hgc_front.sv -----
// ----------------------------------------------------------------------------
// hgc_front
// Input register and classification stage: picks reference and measured
// samples, flags the certainty-one cases, forms the product and the
// divider operands.
// ----------------------------------------------------------------------------
module hgc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  hgc_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  input  logic                          op,
  input  logic [hgc_pkg::PIX_W-1:0]     first_pixel,
  input  logic [hgc_pkg::PIX_W-1:0]     second_pixel,
  input  logic [hgc_pkg::IDX_W-1:0]     table_index,
  input  logic [hgc_pkg::VAL_W-1:0]     table_value,
  output logic                          out_valid,
  output hgc_pkg::side_t                out_side,
  output logic [hgc_pkg::DIVD_W-1:0]    dividend,
  output logic [hgc_pkg::RATIO_W-1:0]   divisor
);

  // Stage one: captured input word.
  logic                      v1;
  logic                      op1;
  logic [hgc_pkg::PIX_W-1:0] a1;
  logic [hgc_pkg::PIX_W-1:0] b1;
  logic [hgc_pkg::IDX_W-1:0] ti1;
  logic [hgc_pkg::VAL_W-1:0] tv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    op1 <= op;
    a1  <= first_pixel;
    b1  <= second_pixel;
    ti1 <= table_index;
    tv1 <= table_value;
  end

  // Stage two: reference selection, special cases and the product.
  logic [hgc_pkg::PIX_W-1:0]  ref_pix;
  logic [hgc_pkg::PIX_W-1:0]  meas_pix;
  logic                       noise;
  logic                       over_clip;
  logic                       div_sat;
  logic [hgc_pkg::PROD_W-1:0] prod;

  always_comb begin
    ref_pix   = cfg.first_is_reference ? a1 : b1;
    meas_pix  = cfg.first_is_reference ? b1 : a1;
    noise     = (ref_pix < cfg.noise_floor) && (meas_pix < cfg.noise_floor);
    over_clip = !cfg.first_is_reference && (ref_pix > cfg.clip_level);
    // The quotient reaches 2^20 (and so the clip) once ref >= 16 * ratio.
    div_sat   = ({cfg.exposure_ratio, 4'b0000} <= {8'b0, ref_pix});
    prod      = hgc_pkg::PROD_W'(ref_pix) * hgc_pkg::PROD_W'(cfg.exposure_ratio);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v1;
    end
    out_side.op        <= op1;
    out_side.force_one <= noise || over_clip;
    out_side.div_sat   <= div_sat;
    out_side.meas      <= meas_pix;
    out_side.prod      <= prod;
    out_side.tbl_index <= ti1;
    out_side.tbl_value <= tv1;
    dividend           <= {ref_pix, 16'b0};
    divisor            <= cfg.exposure_ratio;
  end

endmodule

// ----- design/hgc_div.sv -----
// ----------------------------------------------------------------------------
// hgc_div
// Pipelined restoring divider. Each stage resolves two quotient bits;
// the word fields travel alongside with their valid bit.
// ----------------------------------------------------------------------------
module hgc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  hgc_pkg::side_t                in_side,
  input  logic [hgc_pkg::DIVD_W-1:0]    dividend,
  input  logic [hgc_pkg::RATIO_W-1:0]   divisor,
  output logic                          out_valid,
  output hgc_pkg::side_t                out_side,
  output logic [hgc_pkg::Q_BITS-1:0]    quotient
);

  localparam int STAGES = hgc_pkg::DIV_STAGES;
  localparam int BPS    = hgc_pkg::DIV_BPS;
  localparam int QW     = hgc_pkg::Q_BITS;
  localparam int RW     = hgc_pkg::DIVD_W;
  localparam int TW     = hgc_pkg::RATIO_W + QW;

  logic                        vld [STAGES];
  logic [RW-1:0]               rem [STAGES];
  logic [QW-1:0]               quo [STAGES];
  logic [hgc_pkg::RATIO_W-1:0] dsr [STAGES];
  hgc_pkg::side_t              side [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic                        vld_in;
    logic [RW-1:0]               rem_in;
    logic [QW-1:0]               quo_in;
    logic [hgc_pkg::RATIO_W-1:0] dsr_in;
    hgc_pkg::side_t              side_in;
    logic [RW-1:0]               rem_next;
    logic [QW-1:0]               quo_next;

    if (g == 0) begin : g_head
      assign vld_in  = in_valid;
      assign rem_in  = dividend;
      assign quo_in  = '0;
      assign dsr_in  = divisor;
      assign side_in = in_side;
    end else begin : g_body
      assign vld_in  = vld[g-1];
      assign rem_in  = rem[g-1];
      assign quo_in  = quo[g-1];
      assign dsr_in  = dsr[g-1];
      assign side_in = side[g-1];
    end

    // Trial subtractions for this stage's quotient bits, highest first.
    always_comb begin
      logic [TW-1:0] trial;
      logic          take;
      rem_next = rem_in;
      quo_next = quo_in;
      for (int b = 0; b < BPS; b++) begin
        trial = TW'(dsr_in) << (QW - 1 - g * BPS - b);
        take  = (TW'(rem_next) >= trial);
        if (take) begin
          rem_next = rem_next - trial[RW-1:0];
        end
        quo_next = {quo_next[QW-2:0], take};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else begin
        vld[g] <= vld_in;
      end
      rem[g]  <= rem_next;
      quo[g]  <= quo_next;
      dsr[g]  <= dsr_in;
      side[g] <= side_in;
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_side  = side[STAGES-1];
  assign quotient  = quo[STAGES-1];

  // A word that does not saturate leaves a remainder below the divisor.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (vld[STAGES-1] && !side[STAGES-1].div_sat) |->
      (rem[STAGES-1] < RW'(dsr[STAGES-1])))
    else $error("divider remainder not below divisor");

endmodule

// ----- design/hgc_lookup.sv -----
// ----------------------------------------------------------------------------
// hgc_lookup
// Clamps the expected value, forms the table index from the distance to
// the measured sample, reads or writes the weight table, and drives the
// certainty word.
// ----------------------------------------------------------------------------
module hgc_lookup #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  hgc_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  input  hgc_pkg::side_t              in_side,
  input  logic [hgc_pkg::Q_BITS-1:0]  quotient,
  output logic                        done,
  output logic [hgc_pkg::VAL_W-1:0]   certainty
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = hgc_pkg::EXP_W;

  // Stage one: clamped expected value.
  logic [EW-1:0] clip_q;
  logic [EW-1:0] expected_next;

  always_comb begin
    clip_q = {cfg.clip_level, 8'b0};
    if (cfg.first_is_reference) begin
      expected_next = (in_side.prod > hgc_pkg::SAT_PROD) ? hgc_pkg::SAT_EXP
                                                         : in_side.prod[EW-1:0];
    end else begin
      expected_next = (in_side.div_sat || (quotient > clip_q)) ? clip_q : quotient;
    end
  end

  logic                      l1_valid;
  logic                      l1_op;
  logic                      l1_force;
  logic [EW-1:0]             l1_meas;
  logic [EW-1:0]             l1_expected;
  logic [hgc_pkg::IDX_W-1:0] l1_index;
  logic [hgc_pkg::VAL_W-1:0] l1_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_valid <= 1'b0;
    end else begin
      l1_valid <= in_valid;
    end
    l1_op       <= in_side.op;
    l1_force    <= in_side.force_one;
    l1_meas     <= {in_side.meas, 8'b0};
    l1_expected <= expected_next;
    l1_index    <= in_side.tbl_index;
    l1_value    <= in_side.tbl_value;
  end

  // Stage two: distance, table index and the table access.
  logic [EW-1:0]             diff;
  logic [hgc_pkg::IDX_W-1:0] rd_idx;
  logic                      rd_in_range;
  logic                      wr_in_range;

  always_comb begin
    diff        = (l1_meas > l1_expected) ? (l1_meas - l1_expected)
                                          : (l1_expected - l1_meas);
    rd_idx      = diff[EW-1:EW-hgc_pkg::IDX_W];
    rd_in_range = (32'(rd_idx) < 32'(TABLE_DEPTH));
    wr_in_range = (32'(l1_index) < 32'(TABLE_DEPTH));
  end

  logic [hgc_pkg::VAL_W-1:0] table_mem [TABLE_DEPTH];
  logic [hgc_pkg::VAL_W-1:0] rdata;
  logic                      l2_valid;
  logic                      l2_force;
  logic                      l2_in_range;

  // Writes and reads happen in pipeline order at this one stage.
  always_ff @(posedge clk) begin
    if (l1_valid && (l1_op == hgc_pkg::OP_TABLE_WRITE) && wr_in_range) begin
      table_mem[AW'(l1_index)] <= l1_value;
    end
    if (l1_valid && (l1_op == hgc_pkg::OP_PIXEL)) begin
      rdata <= table_mem[AW'(rd_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l2_valid <= 1'b0;
    end else begin
      l2_valid <= l1_valid && (l1_op == hgc_pkg::OP_PIXEL);
    end
    l2_force    <= l1_force;
    l2_in_range <= rd_in_range;
  end

  // Stage three: output word.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= l2_valid;
    end
    if (l2_force) begin
      certainty <= hgc_pkg::CERT_ONE;
    end else if (l2_in_range) begin
      certainty <= rdata;
    end else begin
      certainty <= hgc_pkg::CERT_ZERO;
    end
  end

  // A result word follows exactly one pixel word at the table stage.
  a_done_from_pixel: assert property (@(posedge clk) disable iff (rst)
    done == $past(l2_valid))
    else $error("result strobe without pixel word");

  // The certainty-one cases bypass the table.
  a_force_one: assert property (@(posedge clk) disable iff (rst)
    (l2_valid && l2_force) |=> (certainty == hgc_pkg::CERT_ONE))
    else $error("forced certainty not one");

  // A distance beyond the table gives zero certainty.
  a_beyond_table: assert property (@(posedge clk) disable iff (rst)
    (l2_valid && !l2_force && !l2_in_range) |=> (certainty == hgc_pkg::CERT_ZERO))
    else $error("distance beyond table not zero");

endmodule

// ----- design/hdr_ghost_certainty.sv -----
// ----------------------------------------------------------------------------
// hdr_ghost_certainty
// Per-pixel ghost certainty for HDR merging with a loadable weight table.
// ----------------------------------------------------------------------------
// A pixel word passes the front registers, the ten divider stages and
// the lookup stages before its certainty word appears.
// Throughput: one word per clock, pixel or table write; busy is never set.
// Reset (rst, synchronous): configuration returns to its defaults and all
// words in flight are dropped; table entries are undefined until written.
// The receiver cannot stall: done marks each certainty for one cycle.
module hdr_ghost_certainty #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op,
  input  logic [hgc_pkg::PIX_W-1:0]   first_pixel,
  input  logic [hgc_pkg::PIX_W-1:0]   second_pixel,
  input  logic [hgc_pkg::IDX_W-1:0]   table_index,
  input  logic [hgc_pkg::VAL_W-1:0]   table_value,
  output logic                        done,
  output logic [hgc_pkg::VAL_W-1:0]   certainty,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_addr,
  input  logic [hgc_pkg::CFG_W-1:0]   cfg_wdata
);

  hgc_pkg::cfg_t cfg;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_is_reference <= 1'b1;
      cfg.exposure_ratio     <= 16'd256;
      cfg.noise_floor        <= 12'd48;
      cfg.clip_level         <= 12'd4048;
    end else if (cfg_write) begin
      case (hgc_pkg::cfg_reg_t'(cfg_addr))
        hgc_pkg::REG_FIRST_IS_REF: begin
          cfg.first_is_reference <= cfg_wdata[0];
        end
        hgc_pkg::REG_EXPOSURE_RATIO: begin
          cfg.exposure_ratio <= cfg_wdata[hgc_pkg::RATIO_W-1:0];
        end
        hgc_pkg::REG_NOISE_FLOOR: begin
          cfg.noise_floor <= cfg_wdata[hgc_pkg::PIX_W-1:0];
        end
        hgc_pkg::REG_CLIP_LEVEL: begin
          cfg.clip_level <= cfg_wdata[hgc_pkg::PIX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The pipeline takes a word every cycle.
  assign busy = 1'b0;

  logic                          fr_valid;
  hgc_pkg::side_t                fr_side;
  logic [hgc_pkg::DIVD_W-1:0]    fr_dividend;
  logic [hgc_pkg::RATIO_W-1:0]   fr_divisor;
  logic                          dv_valid;
  hgc_pkg::side_t                dv_side;
  logic [hgc_pkg::Q_BITS-1:0]    dv_quotient;

  hgc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (start && !busy),
    .op           (op),
    .first_pixel  (first_pixel),
    .second_pixel (second_pixel),
    .table_index  (table_index),
    .table_value  (table_value),
    .out_valid    (fr_valid),
    .out_side     (fr_side),
    .dividend     (fr_dividend),
    .divisor      (fr_divisor)
  );

  hgc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .dividend  (fr_dividend),
    .divisor   (fr_divisor),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .quotient  (dv_quotient)
  );

  hgc_lookup #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_lookup (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (dv_valid),
    .in_side   (dv_side),
    .quotient  (dv_quotient),
    .done      (done),
    .certainty (certainty)
  );

endmodule
